>>> rtl/pid_controller_clamped_core_defines.svh
// Assertion macros shared by the PID controller RTL.
// Included by files that carry concurrent assertions; needs nothing else.
`ifndef PID_CONTROLLER_CLAMPED_CORE_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_CORE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define PCC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcc assertion failed");

// Check cons in the cycle after ante.
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcc assertion failed");

`endif

>>> rtl/pcc_pkg.sv
// Shared types, constants and microcode table of the PID controller.
// No dependencies; compile first after the defines header.
`timescale 1ns / 1ps

package pcc_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DT_FRAC        = 16;
  localparam int W32            = 32;
  localparam int MEAS_W         = 32;
  localparam int TS_W           = 16;
  localparam int DRIVE_W        = 32;
  localparam int ERR_W          = 33;
  localparam int DIFF_W         = 34;
  localparam int LIM_W          = 31;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int DIV_STEPS      = 32;
  localparam int STEP_W         = 4;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_CAP  = 3'd5;

  localparam logic signed [W32-1:0] W32_MAX = {1'b0, {(W32-1){1'b1}}};
  localparam logic signed [W32-1:0] W32_MIN = {1'b1, {(W32-1){1'b0}}};
  localparam logic [LIM_W-1:0]      LIM_RESET = {LIM_W{1'b1}};

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_IDLE   = 4'd0;
  localparam step_t S_ERR    = 4'd1;
  localparam step_t S_DIFF   = 4'd2;
  localparam step_t S_DSTART = 4'd3;
  localparam step_t S_INTEG  = 4'd4;
  localparam step_t S_PLOAD  = 4'd5;
  localparam step_t S_IPOST  = 4'd6;
  localparam step_t S_IADD   = 4'd7;
  localparam step_t S_DWAIT  = 4'd8;
  localparam step_t S_DMUL   = 4'd9;
  localparam step_t S_DPOST  = 4'd10;
  localparam step_t S_DADD   = 4'd11;
  localparam step_t S_FINAL  = 4'd12;
  localparam step_t S_RET    = 4'd13;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_WAIT_IN,
    JC_WAIT_DIV,
    JC_WAIT_OUT,
    JC_JUMP
  } jcond_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_EDT,
    MUL_PTERM,
    MUL_ITERM,
    MUL_DTERM
  } mul_sel_t;

  typedef enum logic [1:0] {
    POST_NONE,
    POST_DT,
    POST_GAIN
  } post_sel_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_ERR,
    DP_DIFF,
    DP_INTEG,
    DP_ACC_LOAD,
    DP_ACC_ADD,
    DP_FINAL
  } dp_op_t;

  typedef struct packed {
    jcond_t    jcond;
    step_t     target;
    mul_sel_t  mul_sel;
    post_sel_t post_sel;
    dp_op_t    dp_op;
    logic      div_start;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic ready;
    logic accept;
    logic commit;
  } pcc_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic div_busy;
    logic out_blocked;
  } pcc_status_t;

  typedef struct packed {
    logic signed [W32-1:0] prop_gain;
    logic signed [W32-1:0] integral_gain;
    logic signed [W32-1:0] deriv_gain;
    logic signed [W32-1:0] setpoint;
    logic [LIM_W-1:0]      output_limit;
    logic [LIM_W-1:0]      integral_cap;
  } cfg_regs_t;

  localparam uop_t UOP_NOP = '{
    jcond:     JC_NEXT,
    target:    S_IDLE,
    mul_sel:   MUL_NONE,
    post_sel:  POST_NONE,
    dp_op:     DP_NONE,
    div_start: 1'b0
  };

  function automatic uop_t ucode(step_t s);
    uop_t w;
    w = UOP_NOP;
    unique case (s)
      S_IDLE: begin
        w.jcond  = JC_WAIT_IN;
        w.target = S_IDLE;
      end
      S_ERR:    w.dp_op = DP_ERR;
      S_DIFF: begin
        w.dp_op   = DP_DIFF;
        w.mul_sel = MUL_EDT;
      end
      S_DSTART: begin
        w.div_start = 1'b1;
        w.post_sel  = POST_DT;
        w.mul_sel   = MUL_PTERM;
      end
      S_INTEG: begin
        w.dp_op    = DP_INTEG;
        w.post_sel = POST_GAIN;
      end
      S_PLOAD: begin
        w.dp_op   = DP_ACC_LOAD;
        w.mul_sel = MUL_ITERM;
      end
      S_IPOST:  w.post_sel = POST_GAIN;
      S_IADD:   w.dp_op    = DP_ACC_ADD;
      S_DWAIT: begin
        w.jcond  = JC_WAIT_DIV;
        w.target = S_DWAIT;
      end
      S_DMUL:   w.mul_sel  = MUL_DTERM;
      S_DPOST:  w.post_sel = POST_GAIN;
      S_DADD:   w.dp_op    = DP_ACC_ADD;
      S_FINAL: begin
        w.dp_op  = DP_FINAL;
        w.jcond  = JC_WAIT_OUT;
        w.target = S_FINAL;
      end
      S_RET: begin
        w.jcond  = JC_JUMP;
        w.target = S_IDLE;
      end
      default: begin
        w.jcond  = JC_JUMP;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/pcc_if.sv
// Valid/ready channel interfaces of the PID controller: input, result, config.
// Depends on pcc_pkg for field widths.
`timescale 1ns / 1ps

interface pcc_in_if import pcc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [MEAS_W-1:0] measurement;
  logic [TS_W-1:0]          time_step;
  modport source (output valid, measurement, time_step, input ready);
  modport sink (input valid, measurement, time_step, output ready);
endinterface

interface pcc_out_if import pcc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  modport source (output valid, drive, input ready);
  modport sink (input valid, drive, output ready);
endinterface

interface pcc_cfg_if import pcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/pcc_sequencer.sv
// Microcode sequencer: step counter over the control table in pcc_pkg.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_sequencer import pcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pcc_status_t status,
  output pcc_ctrl_t   ctrl
);

  step_t step_r;
  step_t step_nxt;
  uop_t  uop;
  logic  take;

  always_comb begin
    uop = ucode(step_r);
    unique case (uop.jcond)
      JC_NEXT:     take = 1'b0;
      JC_WAIT_IN:  take = !status.in_valid;
      JC_WAIT_DIV: take = status.div_busy;
      JC_WAIT_OUT: take = status.out_blocked;
      JC_JUMP:     take = 1'b1;
      default:     take = 1'b1;
    endcase
    step_nxt    = take ? uop.target : step_r + step_t'(1);
    ctrl.uop    = uop;
    ctrl.ready  = (uop.jcond == JC_WAIT_IN);
    ctrl.accept = (uop.jcond == JC_WAIT_IN) && status.in_valid;
    ctrl.commit = (uop.dp_op == DP_FINAL) && !status.out_blocked;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

>>> rtl/pcc_div.sv
// Radix-2 restoring divider for the derivative: (diff * 2^16) / dt, saturated.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_div import pcc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DIFF_W-1:0] diff_i,
  input  logic [TS_W-1:0]          ts_i,
  output logic                     busy_o,
  output logic signed [W32-1:0]    der_o
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [DIFF_W-1:0] mag;
  logic              sat_start;
  logic [TS_W:0]     trial;
  logic [TS_W:0]     trial_sub;
  logic              qbit;

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [TS_W-1:0]  rem_r;
  logic [W32-1:0]   num_r;
  logic [TS_W-1:0]  dvsr_r;
  logic             sat_r;
  logic             neg_r;
  logic             zero_r;

  always_comb begin
    mag       = diff_i[DIFF_W-1] ? DIFF_W'(-diff_i) : DIFF_W'(diff_i);
    sat_start = (diff_i != '0) &&
                (mag >= {{(DIFF_W-TS_W-DT_FRAC){1'b0}}, ts_i, {DT_FRAC{1'b0}}});
    trial     = {rem_r, num_r[W32-1]};
    trial_sub = trial - {1'b0, dvsr_r};
    qbit      = (trial >= {1'b0, dvsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DIV_STEPS - 1);
    end else if (busy_r) begin
      busy_r <= (cnt_r != '0);
      cnt_r  <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= mag[DT_FRAC +: TS_W];
      num_r  <= {mag[DT_FRAC-1:0], {(W32-DT_FRAC){1'b0}}};
      dvsr_r <= ts_i;
      sat_r  <= sat_start;
      neg_r  <= diff_i[DIFF_W-1];
      zero_r <= (diff_i == '0);
    end else if (busy_r) begin
      rem_r <= qbit ? trial_sub[TS_W-1:0] : trial[TS_W-1:0];
      num_r <= {num_r[W32-2:0], qbit};
    end
  end

  always_comb begin
    if (zero_r) begin
      der_o = '0;
    end else if (sat_r) begin
      der_o = neg_r ? W32_MIN : W32_MAX;
    end else if (neg_r) begin
      der_o = (num_r[W32-1] && (num_r[W32-2:0] != '0)) ? W32_MIN : $signed(~num_r + 1'b1);
    end else begin
      der_o = num_r[W32-1] ? W32_MAX : $signed(num_r);
    end
  end

  assign busy_o = busy_r;

endmodule

>>> rtl/pcc_datapath.sv
// Datapath: error, shared multiplier with scaling/saturation stage,
// integral and drive accumulators. Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_datapath import pcc_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pcc_ctrl_t                 ctrl,
  input  cfg_regs_t                 cfg,
  input  logic signed [MEAS_W-1:0]  meas_i,
  input  logic [TS_W-1:0]           ts_i,
  input  logic signed [W32-1:0]     der_i,
  output logic signed [DIFF_W-1:0]  diff_o,
  output logic [TS_W-1:0]           ts_o,
  output logic signed [DRIVE_W-1:0] drive_o
);

  localparam int OP_W   = W32 + 1;
  localparam int PROD_W = 2 * OP_W;
  localparam int SC_W   = (DATA_WIDTH > W32) ? DATA_WIDTH : W32;
  localparam int ACC_W  = (DATA_WIDTH + 2 > W32 + 1) ? DATA_WIDTH + 2 : W32 + 1;
  localparam int SH_MAX = (FRAC_BITS > DT_FRAC) ? FRAC_BITS : DT_FRAC;
  localparam int SH_W   = $clog2(SH_MAX + 1);

  localparam logic signed [PROD_W-1:0] D_MAX_P =
    {{(PROD_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] D_MIN_P = ~D_MAX_P;
  localparam logic signed [PROD_W-1:0] W_MAX_P =
    {{(PROD_W-W32+1){1'b0}}, {(W32-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] W_MIN_P = ~W_MAX_P;
  localparam logic signed [ACC_W-1:0] D_MAX_A =
    {{(ACC_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] D_MIN_A = ~D_MAX_A;

  logic signed [MEAS_W-1:0] meas_r;
  logic [TS_W-1:0]          ts_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [ERR_W-1:0]  last_err_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SC_W-1:0]   scaled_r;
  logic signed [W32-1:0]    int_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [W32-1:0]    err_sat;
  logic signed [OP_W-1:0]   op_a;
  logic signed [OP_W-1:0]   op_b;
  logic [SH_W-1:0]          sh;
  logic signed [PROD_W-1:0] bias;
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [PROD_W-1:0] shifted;
  logic signed [PROD_W-1:0] post_hi;
  logic signed [PROD_W-1:0] post_lo;
  logic signed [PROD_W-1:0] post_val;
  logic signed [W32:0]      int_sum;
  logic signed [W32:0]      cap_p;
  logic signed [W32:0]      int_val;
  logic signed [ACC_W-1:0]  scaled_ext;
  logic signed [ACC_W-1:0]  lim_p;
  logic signed [ACC_W-1:0]  drive_d;
  logic signed [ACC_W-1:0]  drive_l;

  always_comb begin
    if (err_r[ERR_W-1] != err_r[ERR_W-2]) begin
      err_sat = err_r[ERR_W-1] ? W32_MIN : W32_MAX;
    end else begin
      err_sat = err_r[W32-1:0];
    end

    unique case (ctrl.uop.mul_sel)
      MUL_EDT: begin
        op_a = err_r;
        op_b = $signed({{(OP_W-TS_W){1'b0}}, ts_r});
      end
      MUL_PTERM: begin
        op_a = {err_sat[W32-1], err_sat};
        op_b = {cfg.prop_gain[W32-1], cfg.prop_gain};
      end
      MUL_ITERM: begin
        op_a = {int_r[W32-1], int_r};
        op_b = {cfg.integral_gain[W32-1], cfg.integral_gain};
      end
      MUL_DTERM: begin
        op_a = {der_i[W32-1], der_i};
        op_b = {cfg.deriv_gain[W32-1], cfg.deriv_gain};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase

    // Truncate toward zero: bias negative products before the arithmetic shift.
    if (ctrl.uop.post_sel == POST_DT) begin
      sh      = SH_W'(DT_FRAC);
      post_hi = W_MAX_P;
      post_lo = W_MIN_P;
    end else begin
      sh      = SH_W'(FRAC_BITS);
      post_hi = D_MAX_P;
      post_lo = D_MIN_P;
    end
    bias     = $signed(~({PROD_W{1'b1}} << sh));
    prod_adj = prod_r + (prod_r[PROD_W-1] ? bias : PROD_W'(0));
    shifted  = prod_adj >>> sh;
    if (shifted > post_hi) begin
      post_val = post_hi;
    end else if (shifted < post_lo) begin
      post_val = post_lo;
    end else begin
      post_val = shifted;
    end

    int_sum = {int_r[W32-1], int_r} + {scaled_r[W32-1], scaled_r[W32-1:0]};
    cap_p   = $signed({2'b00, cfg.integral_cap});
    if (int_sum > cap_p) begin
      int_val = cap_p;
    end else if (int_sum < -cap_p) begin
      int_val = -cap_p;
    end else begin
      int_val = int_sum;
    end

    scaled_ext = {{(ACC_W-SC_W){scaled_r[SC_W-1]}}, scaled_r};

    lim_p = $signed({{(ACC_W-LIM_W){1'b0}}, cfg.output_limit});
    if (acc_r > D_MAX_A) begin
      drive_d = D_MAX_A;
    end else if (acc_r < D_MIN_A) begin
      drive_d = D_MIN_A;
    end else begin
      drive_d = acc_r;
    end
    if (drive_d > lim_p) begin
      drive_l = lim_p;
    end else if (drive_d < -lim_p) begin
      drive_l = -lim_p;
    end else begin
      drive_l = drive_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_r      <= '0;
      last_err_r <= '0;
    end else begin
      if (ctrl.uop.dp_op == DP_INTEG) begin
        int_r <= int_val[W32-1:0];
      end
      if (ctrl.commit) begin
        last_err_r <= err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      meas_r <= meas_i;
      ts_r   <= ts_i;
    end
    if (ctrl.uop.mul_sel != MUL_NONE) begin
      prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
    end
    if (ctrl.uop.post_sel != POST_NONE) begin
      scaled_r <= post_val[SC_W-1:0];
    end
    unique case (ctrl.uop.dp_op)
      DP_ERR:      err_r  <= {cfg.setpoint[W32-1], cfg.setpoint} - {meas_r[MEAS_W-1], meas_r};
      DP_DIFF:     diff_r <= {err_r[ERR_W-1], err_r} - {last_err_r[ERR_W-1], last_err_r};
      DP_ACC_LOAD: acc_r  <= scaled_ext;
      DP_ACC_ADD:  acc_r  <= acc_r + scaled_ext;
      default: ;
    endcase
  end

  assign diff_o  = diff_r;
  assign ts_o    = ts_r;
  assign drive_o = drive_l[DRIVE_W-1:0];

endmodule

>>> rtl/pid_controller_clamped_core.sv
// PID controller with integral clamp and output limit, signed Q16.16.
// Channels: in_ch carries measurement and time_step, out_ch carries drive,
// cfg_ch writes the six registers by index (prop_gain, integral_gain,
// deriv_gain, setpoint, output_limit, integral_cap); cfg_ch is always ready.
// All transfers happen where valid and ready are both high.
// One sample at a time: in_ch is ready only while the sequencer sits in idle.
// Each sample passes through the 32-step radix-2 divider that forms the
// derivative and the shared multiplier pipeline that serves the four products.
// A result waits in the output register while out_ch is stalled; the next
// sample is accepted and runs meanwhile, and its last step holds until the
// pending result has been transferred.
// Reset (synchronous, rst_n low) clears the integral and the stored error,
// sets gains and setpoint to zero and both limits to their maximum, and drops
// any pending result. Depends on pcc_pkg, pcc_if and the defines header.
`timescale 1ns / 1ps
`include "pid_controller_clamped_core_defines.svh"

module pid_controller_clamped_core import pcc_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  pcc_in_if.sink    in_ch,
  pcc_out_if.source out_ch,
  pcc_cfg_if.sink   cfg_ch
);

  cfg_regs_t                 cfg_r;
  logic                      out_valid_r;
  logic signed [DRIVE_W-1:0] drive_r;

  pcc_ctrl_t                 ctrl;
  pcc_status_t               status;
  logic signed [DIFF_W-1:0]  diff;
  logic [TS_W-1:0]           ts;
  logic signed [W32-1:0]     der;
  logic                      div_busy;
  logic signed [DRIVE_W-1:0] drive_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain     <= '0;
      cfg_r.integral_gain <= '0;
      cfg_r.deriv_gain    <= '0;
      cfg_r.setpoint      <= '0;
      cfg_r.output_limit  <= LIM_RESET;
      cfg_r.integral_cap  <= LIM_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_PROP_GAIN:     cfg_r.prop_gain     <= $signed(cfg_ch.data[W32-1:0]);
        REG_INTEGRAL_GAIN: cfg_r.integral_gain <= $signed(cfg_ch.data[W32-1:0]);
        REG_DERIV_GAIN:    cfg_r.deriv_gain    <= $signed(cfg_ch.data[W32-1:0]);
        REG_SETPOINT:      cfg_r.setpoint      <= $signed(cfg_ch.data[W32-1:0]);
        REG_OUTPUT_LIMIT:  cfg_r.output_limit  <= cfg_ch.data[LIM_W-1:0];
        REG_INTEGRAL_CAP:  cfg_r.integral_cap  <= cfg_ch.data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign status.in_valid    = in_ch.valid;
  assign status.div_busy    = div_busy;
  assign status.out_blocked = out_valid_r && !out_ch.ready;

  pcc_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  pcc_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .cfg     (cfg_r),
    .meas_i  (in_ch.measurement),
    .ts_i    (in_ch.time_step),
    .der_i   (der),
    .diff_o  (diff),
    .ts_o    (ts),
    .drive_o (drive_val)
  );

  pcc_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ctrl.uop.div_start),
    .diff_i (diff),
    .ts_i   (ts),
    .busy_o (div_busy),
    .der_o  (der)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      drive_r <= drive_val;
    end
  end

  assign in_ch.ready  = ctrl.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.drive = drive_r;

  `PCC_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `PCC_ASSERT_NEXT(a_div_starts, clk, rst_n, ctrl.uop.div_start, div_busy)
  `PCC_ASSERT_SAME(a_commit_after_div, clk, rst_n, ctrl.commit, !div_busy)
  `PCC_ASSERT_SAME(a_commit_not_blocked, clk, rst_n, ctrl.commit, !out_valid_r || out_ch.ready)

endmodule

>>> bench/tb_pid_controller_clamped_core.sv
// Self-checking bench for pid_controller_clamped_core: drives samples and register writes,
// predicts each drive value in 64-bit integer math and checks every result transfer.
// Depends on pcc_pkg, the pcc_if channel interfaces and the core RTL.
`timescale 1ns / 1ps

module tb_pid_controller_clamped_core;
  import pcc_pkg::*;

  localparam int CLK_HIGH      = 6;
  localparam int CLK_LOW       = 6;
  localparam int RESET_CYCLES  = 8;
  localparam int SAMPLE_CYCLES = 42;
  localparam int QUIET_LIMIT   = 2000;
  localparam int REPORT_LIMIT  = 10;
  localparam int RAND_PHASES   = 10;
  localparam int PHASE_ITEMS   = 96;
  localparam int LAST_ITEMS    = 60;
  localparam int LONG_HOLD     = 300;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam longint W32_HI = longint'(W32_MAX);
  localparam longint W32_LO = longint'(W32_MIN);
  localparam longint DW_HI  = (longint'(1) << (DATA_WIDTH_DEF - 1)) - 1;
  localparam longint DW_LO  = -DW_HI - 1;

  class drive_checker;
    cfg_regs_t                 regs;
    longint                    integ;
    longint                    last_err;
    logic signed [DRIVE_W-1:0] drive_due[$];
    int                        errors;
    int                        checked;

    function void reset_state();
      regs.prop_gain     = '0;
      regs.integral_gain = '0;
      regs.deriv_gain    = '0;
      regs.setpoint      = '0;
      regs.output_limit  = LIM_RESET;
      regs.integral_cap  = LIM_RESET;
      integ              = 0;
      last_err           = 0;
      errors             = 0;
      checked            = 0;
      drive_due.delete();
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function longint gain_term(longint gain, longint operand);
      longint p;
      p = gain * sat(operand, W32_LO, W32_HI);
      return sat(p / (longint'(1) << FRAC_BITS_DEF), DW_LO, DW_HI);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PROP_GAIN:     regs.prop_gain     = data;
        REG_INTEGRAL_GAIN: regs.integral_gain = data;
        REG_DERIV_GAIN:    regs.deriv_gain    = data;
        REG_SETPOINT:      regs.setpoint      = data;
        REG_OUTPUT_LIMIT:  regs.output_limit  = data[LIM_W-1:0];
        REG_INTEGRAL_CAP:  regs.integral_cap  = data[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic signed [MEAS_W-1:0] meas, logic [TS_W-1:0] ts);
      longint e, diff, der, edt, acc, drv, tsl, cap, lim;
      tsl  = ts;
      cap  = regs.integral_cap;
      lim  = regs.output_limit;
      e    = longint'($signed(regs.setpoint)) - longint'(meas);
      diff = e - last_err;
      if (tsl != 0) der = (diff * (longint'(1) << DT_FRAC)) / tsl;
      else if (diff > 0) der = W32_HI;
      else if (diff < 0) der = W32_LO;
      else der = 0;
      der   = sat(der, W32_LO, W32_HI);
      edt   = sat((e * tsl) / (longint'(1) << DT_FRAC), W32_LO, W32_HI);
      acc   = sat(integ + edt, -cap, cap);
      integ = acc;
      drv   = gain_term(longint'($signed(regs.prop_gain)), e)
            + gain_term(longint'($signed(regs.integral_gain)), acc)
            + gain_term(longint'($signed(regs.deriv_gain)), der);
      drv   = sat(drv, DW_LO, DW_HI);
      drv   = sat(drv, -lim, lim);
      last_err = e;
      drive_due.push_back(drv[DRIVE_W-1:0]);
    endfunction

    function void check_drive(logic signed [DRIVE_W-1:0] actual);
      logic signed [DRIVE_W-1:0] want;
      if (drive_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) $display("unexpected drive %0d with nothing pending", actual);
        return;
      end
      want = drive_due.pop_front();
      checked++;
      if (actual !== want) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("drive mismatch on result %0d: expected %0d (0x%08h), got %0d (0x%08h)",
                   checked, want, want, actual, actual);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pcc_in_if  in_ch();
  pcc_out_if out_ch();
  pcc_cfg_if cfg_ch();

  pid_controller_clamped_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  drive_checker sb = new;

  bit                 hold_results = 1'b0;
  int                 idle_pct = 0;
  int                 ready_gap = 0;
  int                 quiet_cycles = 0;
  int                 samples_sent = 0;
  int                 zero_steps = 0;
  int                 cfg_writes = 0;
  logic signed [31:0] walk = '0;

  always begin
    #CLK_LOW clk = 1'b1;
    #CLK_HIGH clk = 1'b0;
  end

  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_drive(out_ch.drive);
        moved = 1'b1;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        sb.write_reg(cfg_ch.index, cfg_ch.data);
        moved = 1'b1;
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.take_sample(in_ch.measurement, in_ch.time_step);
        moved = 1'b1;
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("tb_pid_controller_clamped_core: done, errors");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_results) begin
      out_ch.ready <= 1'b0;
    end else if (ready_gap > 0) begin
      out_ch.ready <= 1'b0;
      ready_gap--;
    end else if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      out_ch.ready <= 1'b0;
      ready_gap = $urandom_range(6, 1) - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic write_all(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                           logic [31:0] sp, logic [31:0] lim, logic [31:0] cap);
    write_cfg(REG_PROP_GAIN, kp);
    write_cfg(REG_INTEGRAL_GAIN, ki);
    write_cfg(REG_DERIV_GAIN, kd);
    write_cfg(REG_SETPOINT, sp);
    write_cfg(REG_OUTPUT_LIMIT, lim);
    write_cfg(REG_INTEGRAL_CAP, cap);
  endtask

  task automatic send_sample(logic signed [MEAS_W-1:0] m, logic [TS_W-1:0] ts);
    int gap;
    if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      gap = $urandom_range(6, 1);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.measurement <= m;
    in_ch.time_step   <= ts;
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
    if (ts == '0) zero_steps++;
  endtask

  task automatic drain(int extra);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.drive_due.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic hold_results_for(int n);
    @(posedge clk);
    hold_results = 1'b1;
    repeat (n) @(posedge clk);
    hold_results = 1'b0;
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(7, 0))
      0:       return W32_MAX;
      1:       return W32_MIN;
      2:       return '0;
      3, 4:    return $urandom();
      default: return $urandom_range(32'h30000, 0) - 32'h18000;
    endcase
  endfunction

  function automatic logic [31:0] pick_setpoint();
    case ($urandom_range(5, 0))
      0:       return W32_MAX;
      1:       return W32_MIN;
      2, 3:    return $urandom();
      default: return $urandom_range(32'h200000, 0) - 32'h100000;
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    logic [31:0] v;
    case ($urandom_range(5, 0))
      0:       v = 32'h7FFFFFFF;
      1:       v = '0;
      2:       v = $urandom_range(32'h80000, 1);
      3:       v = $urandom_range(32'h4000000, 0);
      default: v = $urandom();
    endcase
    v[31] = 1'($urandom_range(1, 0));
    return v;
  endfunction

  function automatic logic [TS_W-1:0] pick_step();
    case ($urandom_range(19, 0))
      0:       return '0;
      1:       return 16'hFFFF;
      2, 3:    return TS_W'($urandom_range(16, 1));
      default: return TS_W'($urandom_range(65535, 1));
    endcase
  endfunction

  function automatic logic signed [MEAS_W-1:0] next_measurement();
    case ($urandom_range(19, 0))
      0:       return W32_MAX;
      1:       return W32_MIN;
      2, 3:    return $urandom();
      default: begin
        walk = walk + ($urandom_range(32'h20000, 0) - 32'h10000);
        return walk;
      end
    endcase
  endfunction

  initial begin
    logic [31:0] sp;
    int          n_items;
    in_ch.valid       = 1'b0;
    in_ch.measurement = '0;
    in_ch.time_step   = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    sb.reset_state();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration: gains zero, state still accumulates
    send_sample(W32_MAX, 16'hFFFF);
    send_sample(W32_MIN, 16'h0000);
    drain(2);

    write_all(32'h10000, 32'h8000, 32'h4000, 32'h10000, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_sample(32'sh0, 16'h8000);
    send_sample(32'sh0, 16'h0000);
    send_sample(32'sh20000, 16'h0000);
    send_sample(32'sh0, 16'h0000);
    send_sample(W32_MIN, 16'h0001);
    send_sample(W32_MAX, 16'hFFFF);
    send_sample(-32'sd1, 16'h0001);
    send_sample(W32_MAX, 16'h0001);
    drain(2);

    // extreme gains and setpoint; limit writes with the unused top bit set
    write_all(W32_MAX, W32_MIN, W32_MAX, W32_MIN, 32'h80012345, 32'h80040000);
    write_cfg(REG_SPARE_LO, $urandom());
    write_cfg(REG_SPARE_HI, $urandom());
    send_sample(W32_MAX, 16'hFFFF);
    send_sample(W32_MIN, 16'h0001);
    send_sample(32'sh0, 16'h0000);
    send_sample(32'sh12345678, 16'h1234);
    send_sample(W32_MAX, 16'h0000);
    drain(2);

    // zero limits: drive and integral pinned at zero
    write_all(W32_MIN, W32_MAX, W32_MIN, 32'h0, 32'h0, 32'h0);
    send_sample(W32_MAX, 16'hFFFF);
    send_sample(W32_MIN, 16'h0000);
    send_sample(32'sh10000, 16'h0100);
    drain(2);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      sp = pick_setpoint();
      write_all(pick_gain(), pick_gain(), pick_gain(), sp, pick_limit(), pick_limit());
      if ($urandom_range(3, 0) == 0)
        write_cfg($urandom_range(1, 0) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
      walk = sp;
      if (ph == RAND_PHASES - 1) begin
        idle_pct = 0;
        n_items  = LAST_ITEMS;
      end else begin
        case ($urandom_range(2, 0))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 30;
        endcase
        n_items = PHASE_ITEMS;
      end
      for (int i = 0; i < n_items; i++) begin
        if (ph == 3 && i == 20) begin
          fork
            hold_results_for(LONG_HOLD);
          join_none
        end
        if (ph == 5 && i == PHASE_ITEMS / 2) drain(0);
        send_sample(next_measurement(), pick_step());
      end
      drain(ph == RAND_PHASES - 1 ? SAMPLE_CYCLES : 2);
    end

    $display("covered %0d samples (%0d with zero time step), %0d register writes",
             samples_sent, zero_steps, cfg_writes);
    $display("%0d drives checked over directed extremes and %0d random phases",
             sb.checked, RAND_PHASES);
    if (sb.drive_due.size() != 0)
      $display("%0d expected drives never arrived", sb.drive_due.size());
    if (sb.errors == 0 && sb.drive_due.size() == 0) begin
      $display("tb_pid_controller_clamped_core: done, clean");
    end else begin
      $display("tb_pid_controller_clamped_core: done, errors");
    end
    $finish;
  end

endmodule
